/* rtl/core/amm_pkg.sv */
// ----------------------------------------------------------------------------
// amm_pkg - shared types and constants for the assignment cost solver
// Payload structs, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package amm_pkg;

	localparam int MAX_N_DEF = 64;
	localparam int COST_W    = 16;
	localparam int DIST_W    = 26;
	localparam int TOTAL_W   = 23;
	localparam int RES_W     = 22;
	localparam int CFG_W     = 7;

	typedef struct packed {
		logic [5:0]        row_index;
		logic [5:0]        col_index;
		logic [COST_W-1:0] entry_cost;
		logic              last_entry;
	} in_t;

	typedef struct packed {
		logic [RES_W-1:0] min_total_cost;
		logic [RES_W-1:0] max_total_cost;
	} out_t;

	typedef enum logic [1:0] {
		V_SRC,
		V_ROW,
		V_COL,
		V_NONE
	} visit_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SOLVE_INIT,
		S_FP_INIT,
		S_POP_RD,
		S_POP,
		S_VISIT,
		S_REL_A,
		S_REL_B,
		S_FP_END,
		S_ADD,
		S_AUG_RD,
		S_AUG_WR,
		S_PASS_END,
		S_OUT
	} state_t;

endpackage

/* rtl/core/amm_ram.sv */
// ----------------------------------------------------------------------------
// amm_ram - simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module amm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/amm_relax.sv */
// ----------------------------------------------------------------------------
// amm_relax - shared edge relaxation unit
// Forms the candidate distance over one edge and decides whether it improves.
// ----------------------------------------------------------------------------
module amm_relax (
	input  logic signed [amm_pkg::DIST_W-1:0] du,
	input  logic signed [amm_pkg::DIST_W-1:0] dv,
	input  logic        [amm_pkg::COST_W-1:0] cost,
	input  logic                              wzero,
	input  logic                              wneg,
	input  logic                              reached,
	output logic signed [amm_pkg::DIST_W-1:0] cand,
	output logic                              take
);

	logic signed [amm_pkg::DIST_W-1:0] cw;
	logic signed [amm_pkg::DIST_W-1:0] w;

	always_comb begin
		cw = $signed(amm_pkg::DIST_W'(cost));
		if (wzero) begin
			w = '0;
		end else if (wneg) begin
			w = -cw;
		end else begin
			w = cw;
		end
		cand = du + w;
		take = !reached || (cand < dv);
	end

endmodule

/* rtl/core/assignment_min_max_cost_core.sv */
// ----------------------------------------------------------------------------
// assignment_min_max_cost_core - min and max cost perfect assignment solver
// Loads cost entries, then runs two SPFA successive shortest path passes.
// ----------------------------------------------------------------------------
// Load: one entry per cycle. After the last entry, the solve runs two passes of
// up to n+1 augmenting rounds; a visit pops a node, reads its distance and matches,
// then relaxes its residual edges through the one shared relaxation unit and
// distance RAM. Each round then augments along the path; input is not ready.
// Reset clears control state and flags; the cost store is undefined until written.
// ----------------------------------------------------------------------------
module assignment_min_max_cost_core #(
	parameter int MAX_N = amm_pkg::MAX_N_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  amm_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output amm_pkg::out_t             out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [amm_pkg::CFG_W-1:0] cfg_data
);

	localparam int NODE_COUNT = 2 * MAX_N + 2;
	localparam int NDW = $clog2(NODE_COUNT);
	localparam int NW  = $clog2(MAX_N + 1);
	localparam int RW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
	localparam int CDEPTH = MAX_N * MAX_N;
	localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int DW  = amm_pkg::DIST_W;
	localparam int TW  = amm_pkg::TOTAL_W;
	localparam int RSW = amm_pkg::RES_W;

	amm_pkg::state_t state_q, state_d;
	amm_pkg::visit_t kind_q, kind_w;

	logic [amm_pkg::CFG_W-1:0] size_q;
	logic [NW-1:0]   n_q, n_clamp;
	logic            sign_neg_q;
	logic [TW-1:0]   total_q;
	logic [RSW-1:0]  min_q;
	logic [NW:0]     rounds_q;
	logic [NDW-1:0]  head_q, tail_q, u_q, v_q;
	logic [NDW:0]    count_q;
	logic [DW-1:0]   du_q;
	logic [NW-1:0]   idx_q, lim_q, lim_w;
	logic [RW-1:0]   rm_q, cm_q;
	logic            wzero_q, wneg_q;
	logic [NODE_COUNT-1:0] reached_q, queued_q;
	logic [MAX_N-1:0] rv_q, cv_q;
	logic            out_valid_q;
	amm_pkg::out_t   out_q;

	logic [NDW-1:0] sink_w, q_node, r_node, c_node, ur_node, uc_node, pred_u;
	logic [NDW-1:0] head_nx, tail_nx;
	logic [NW-1:0]  idx_nx;
	logic           present;
	logic [NDW-1:0] rel_v;
	logic [CAW-1:0] rel_addr;
	logic           rel_zero, rel_neg;

	// memory ports
	logic            c_we, c_re, d_we, d_re, p_we, p_re, q_we, q_re;
	logic            rm_we, rm_re, cm_we, cm_re;
	logic [CAW-1:0]  c_waddr, c_raddr;
	logic [NDW-1:0]  d_waddr, d_raddr, p_waddr, p_raddr, q_waddr, q_raddr, q_wdata;
	logic [RW-1:0]   rm_waddr, rm_raddr, cm_waddr, cm_raddr, rm_wdata, cm_wdata;
	logic [DW-1:0]   d_wdata, d_rdata;
	logic [amm_pkg::COST_W-1:0] c_rdata;
	logic [NDW-1:0]  p_rdata, q_rdata;
	logic [RW-1:0]   rm_rdata, cm_rdata;

	logic signed [DW-1:0] cand;
	logic                 take;

	amm_ram #(.DEPTH(CDEPTH), .WIDTH(amm_pkg::COST_W), .AW(CAW)) u_cost (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(in_data.entry_cost),
		.re(c_re), .raddr(c_raddr), .rdata(c_rdata)
	);
	amm_ram #(.DEPTH(NODE_COUNT), .WIDTH(DW), .AW(NDW)) u_dist (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.re(d_re), .raddr(d_raddr), .rdata(d_rdata)
	);
	amm_ram #(.DEPTH(NODE_COUNT), .WIDTH(NDW), .AW(NDW)) u_pred (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(u_q),
		.re(p_re), .raddr(p_raddr), .rdata(p_rdata)
	);
	amm_ram #(.DEPTH(NODE_COUNT), .WIDTH(NDW), .AW(NDW)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.re(q_re), .raddr(q_raddr), .rdata(q_rdata)
	);
	amm_ram #(.DEPTH(MAX_N), .WIDTH(RW), .AW(RW)) u_row_match (
		.clk(clk), .we(rm_we), .waddr(rm_waddr), .wdata(rm_wdata),
		.re(rm_re), .raddr(rm_raddr), .rdata(rm_rdata)
	);
	amm_ram #(.DEPTH(MAX_N), .WIDTH(RW), .AW(RW)) u_col_match (
		.clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
		.re(cm_re), .raddr(cm_raddr), .rdata(cm_rdata)
	);

	amm_relax u_relax (
		.du(du_q), .dv(d_rdata), .cost(c_rdata), .wzero(wzero_q), .wneg(wneg_q),
		.reached(reached_q[v_q]), .cand(cand), .take(take)
	);

	// node bookkeeping
	always_comb begin
		sink_w  = (NDW'(n_q) << 1) + NDW'(1);
		q_node  = q_rdata;
		r_node  = q_node - NDW'(1);
		c_node  = q_node - NDW'(1) - NDW'(n_q);
		ur_node = u_q - NDW'(1);
		uc_node = u_q - NDW'(1) - NDW'(n_q);
		pred_u  = p_rdata;
		head_nx = (head_q == NDW'(NODE_COUNT - 1)) ? '0 : head_q + NDW'(1);
		tail_nx = (tail_q == NDW'(NODE_COUNT - 1)) ? '0 : tail_q + NDW'(1);
		idx_nx  = idx_q + NW'(1);
		if (size_q == '0) begin
			n_clamp = NW'(1);
		end else if (32'(size_q) > MAX_N) begin
			n_clamp = NW'(MAX_N);
		end else begin
			n_clamp = NW'(size_q);
		end
		if (u_q == '0) begin
			kind_w = amm_pkg::V_SRC;
			lim_w  = n_q;
		end else if (u_q <= NDW'(n_q)) begin
			kind_w = amm_pkg::V_ROW;
			lim_w  = n_q;
		end else if (u_q < sink_w) begin
			kind_w = amm_pkg::V_COL;
			lim_w  = NW'(2);
		end else begin
			kind_w = amm_pkg::V_NONE;
			lim_w  = '0;
		end
	end

	// edge under the cursor of the current visit
	always_comb begin
		present  = 1'b0;
		rel_v    = '0;
		rel_addr = '0;
		rel_zero = 1'b1;
		rel_neg  = 1'b0;
		case (kind_q)
			amm_pkg::V_SRC: begin
				present = !rv_q[idx_q[RW-1:0]];
				rel_v   = NDW'(idx_q) + NDW'(1);
			end
			amm_pkg::V_ROW: begin
				present  = !(rv_q[ur_node[RW-1:0]] && (NW'(rm_q) == idx_q));
				rel_v    = NDW'(n_q) + NDW'(1) + NDW'(idx_q);
				rel_addr = CAW'(ur_node[RW-1:0]) * CAW'(MAX_N) + CAW'(idx_q);
				rel_zero = 1'b0;
				rel_neg  = sign_neg_q;
			end
			amm_pkg::V_COL: begin
				if (idx_q == '0) begin
					present = !cv_q[uc_node[RW-1:0]];
					rel_v   = sink_w;
				end else begin
					present  = cv_q[uc_node[RW-1:0]];
					rel_v    = NDW'(cm_q) + NDW'(1);
					rel_addr = CAW'(cm_q) * CAW'(MAX_N) + CAW'(uc_node[RW-1:0]);
					rel_zero = 1'b0;
					rel_neg  = !sign_neg_q;
				end
			end
			default: begin
				present = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			amm_pkg::S_IDLE: begin
				if (in_valid && in_data.last_entry) begin
					state_d = amm_pkg::S_SOLVE_INIT;
				end
			end
			amm_pkg::S_SOLVE_INIT: state_d = amm_pkg::S_FP_INIT;
			amm_pkg::S_FP_INIT:    state_d = amm_pkg::S_POP_RD;
			amm_pkg::S_POP_RD: begin
				state_d = (count_q == '0) ? amm_pkg::S_FP_END : amm_pkg::S_POP;
			end
			amm_pkg::S_POP:        state_d = amm_pkg::S_VISIT;
			amm_pkg::S_VISIT: begin
				state_d = (lim_w == '0) ? amm_pkg::S_POP_RD : amm_pkg::S_REL_A;
			end
			amm_pkg::S_REL_A: begin
				if (present) begin
					state_d = amm_pkg::S_REL_B;
				end else if (idx_nx == lim_q) begin
					state_d = amm_pkg::S_POP_RD;
				end
			end
			amm_pkg::S_REL_B: begin
				state_d = (idx_nx == lim_q) ? amm_pkg::S_POP_RD : amm_pkg::S_REL_A;
			end
			amm_pkg::S_FP_END: begin
				if (reached_q[sink_w] && (rounds_q <= {1'b0, n_q})) begin
					state_d = amm_pkg::S_ADD;
				end else begin
					state_d = amm_pkg::S_PASS_END;
				end
			end
			amm_pkg::S_ADD:    state_d = amm_pkg::S_AUG_RD;
			amm_pkg::S_AUG_RD: state_d = amm_pkg::S_AUG_WR;
			amm_pkg::S_AUG_WR: begin
				state_d = (pred_u == '0) ? amm_pkg::S_FP_INIT : amm_pkg::S_AUG_RD;
			end
			amm_pkg::S_PASS_END: begin
				state_d = sign_neg_q ? amm_pkg::S_OUT : amm_pkg::S_SOLVE_INIT;
			end
			amm_pkg::S_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = amm_pkg::S_IDLE;
				end
			end
			default: state_d = amm_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		c_we = 1'b0; c_re = 1'b0; d_we = 1'b0; d_re = 1'b0;
		p_we = 1'b0; p_re = 1'b0; q_we = 1'b0; q_re = 1'b0;
		rm_we = 1'b0; rm_re = 1'b0; cm_we = 1'b0; cm_re = 1'b0;
		c_waddr = CAW'(in_data.row_index) * CAW'(MAX_N) + CAW'(in_data.col_index);
		c_raddr = rel_addr;
		d_waddr = v_q;
		d_wdata = cand;
		d_raddr = rel_v;
		p_waddr = v_q;
		p_raddr = v_q;
		q_waddr = tail_q;
		q_wdata = v_q;
		q_raddr = head_q;
		rm_waddr = pred_u[RW-1:0] - RW'(1);
		rm_wdata = RW'(v_q - NDW'(1) - NDW'(n_q));
		cm_waddr = rm_wdata;
		cm_wdata = rm_waddr;
		rm_raddr = r_node[RW-1:0];
		cm_raddr = c_node[RW-1:0];
		unique case (state_q)
			amm_pkg::S_IDLE: begin
				c_we = in_valid && (32'(in_data.row_index) < MAX_N)
					&& (32'(in_data.col_index) < MAX_N);
			end
			amm_pkg::S_FP_INIT: begin
				d_we    = 1'b1;
				d_waddr = '0;
				d_wdata = '0;
				q_we    = 1'b1;
				q_waddr = '0;
				q_wdata = '0;
			end
			amm_pkg::S_POP_RD: q_re = 1'b1;
			amm_pkg::S_POP: begin
				d_re    = 1'b1;
				d_raddr = q_node;
				rm_re   = 1'b1;
				cm_re   = 1'b1;
			end
			amm_pkg::S_REL_A: begin
				d_re = present;
				c_re = present && !rel_zero;
			end
			amm_pkg::S_REL_B: begin
				d_we = take;
				p_we = take;
				q_we = take && !queued_q[v_q];
			end
			amm_pkg::S_FP_END: begin
				d_re    = 1'b1;
				d_raddr = sink_w;
			end
			amm_pkg::S_AUG_RD: p_re = 1'b1;
			amm_pkg::S_AUG_WR: begin
				// row to column edge on the path becomes the row's match
				if ((pred_u != '0) && (pred_u <= NDW'(n_q)) && (v_q > NDW'(n_q))
						&& (v_q < sink_w)) begin
					rm_we = 1'b1;
					cm_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= amm_pkg::S_IDLE;
			size_q      <= amm_pkg::CFG_W'(1);
			out_valid_q <= 1'b0;
			reached_q   <= '0;
			queued_q    <= '0;
			rv_q        <= '0;
			cv_q        <= '0;
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				size_q <= cfg_data;
			end
			if ((state_q == amm_pkg::S_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				amm_pkg::S_SOLVE_INIT: begin
					rv_q <= '0;
					cv_q <= '0;
				end
				amm_pkg::S_FP_INIT: begin
					// only the source is reached and queued
					reached_q <= NODE_COUNT'(1);
					queued_q  <= NODE_COUNT'(1);
					head_q    <= '0;
					tail_q    <= NDW'(1);
					count_q   <= (NDW + 1)'(1);
				end
				amm_pkg::S_POP: begin
					head_q           <= head_nx;
					count_q          <= count_q - (NDW + 1)'(1);
					queued_q[q_node] <= 1'b0;
				end
				amm_pkg::S_REL_B: begin
					if (take) begin
						reached_q[v_q] <= 1'b1;
						if (!queued_q[v_q]) begin
							queued_q[v_q] <= 1'b1;
							tail_q        <= tail_nx;
							count_q       <= count_q + (NDW + 1)'(1);
						end
					end
				end
				amm_pkg::S_AUG_WR: begin
					if (rm_we) begin
						rv_q[rm_waddr] <= 1'b1;
						cv_q[cm_waddr] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			amm_pkg::S_IDLE: begin
				n_q        <= n_clamp;
				sign_neg_q <= 1'b0;
			end
			amm_pkg::S_SOLVE_INIT: begin
				total_q  <= '0;
				rounds_q <= '0;
			end
			amm_pkg::S_POP: u_q <= q_node;
			amm_pkg::S_VISIT: begin
				du_q   <= d_rdata;
				rm_q   <= rm_rdata;
				cm_q   <= cm_rdata;
				kind_q <= kind_w;
				lim_q  <= lim_w;
				idx_q  <= '0;
			end
			amm_pkg::S_REL_A: begin
				v_q     <= rel_v;
				wzero_q <= rel_zero;
				wneg_q  <= rel_neg;
				if (!present) begin
					idx_q <= idx_nx;
				end
			end
			amm_pkg::S_REL_B: idx_q <= idx_nx;
			amm_pkg::S_ADD: begin
				total_q <= total_q + d_rdata[TW-1:0];
				v_q     <= sink_w;
			end
			amm_pkg::S_AUG_WR: begin
				v_q <= pred_u;
				if (pred_u == '0) begin
					rounds_q <= rounds_q + (NW + 1)'(1);
				end
			end
			amm_pkg::S_PASS_END: begin
				if (!sign_neg_q) begin
					min_q <= total_q[RSW-1:0];
				end
				sign_neg_q <= 1'b1;
			end
			amm_pkg::S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q.min_total_cost <= min_q;
					out_q.max_total_cost <= RSW'(-total_q);
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == amm_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
